>>> rtl/fns_pkg.sv
// fns_pkg: shared types and constants for the five-number summary block
// controller states, command and status bundles, summary read slots
// no dependencies
`timescale 1ns / 1ps

package fns_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_SUM_READ,
    ST_SUM_WAIT,
    ST_CALC_QUART,
    ST_CALC_FENCE
  } state_t;

  // summary read slots, one store entry each
  localparam int unsigned SLOT_MIN   = 0;
  localparam int unsigned SLOT_MAX   = 1;
  localparam int unsigned SLOT_MED_X = 2;
  localparam int unsigned SLOT_MED_Y = 3;
  localparam int unsigned SLOT_Q1_X  = 4;
  localparam int unsigned SLOT_Q1_Y  = 5;
  localparam int unsigned SLOT_Q3_X  = 6;
  localparam int unsigned SLOT_Q3_Y  = 7;
  localparam int unsigned NUM_SLOTS  = 8;
  localparam int unsigned SLOT_BITS  = 3;

  typedef struct packed {
    logic accept;     // latch sample, start insertion
    logic drop;       // store full, discard sample
    logic shift;      // move compared entry up one place
    logic place;      // write sample into the hole, bump count
    logic sum_read;   // issue next summary read
    logic calc_quart; // register median and quartiles
    logic finish;     // register fences, raise done, clear set
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic greater;
    logic pos_one;
    logic last_q;
    logic slot_last;
  } status_t;

endpackage

>>> rtl/fns_ram.sv
// fns_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module fns_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fns_ctrl.sv
// fns_ctrl: controller for the five-number summary block
// sequences insertion, summary reads and result arithmetic; uses fns_pkg
`timescale 1ns / 1ps

module fns_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last,
  input  fns_pkg::status_t status,
  output fns_pkg::cmd_t    cmd,
  output logic             busy
);

  fns_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fns_pkg::ST_IDLE: begin
        if (start) begin
          if (status.full) begin
            state_next = last ? fns_pkg::ST_SUM_READ : fns_pkg::ST_IDLE;
          end else if (status.empty) begin
            state_next = fns_pkg::ST_PLACE;
          end else begin
            state_next = fns_pkg::ST_SHIFT;
          end
        end
      end
      fns_pkg::ST_SHIFT: begin
        if (status.greater) begin
          state_next = status.pos_one ? fns_pkg::ST_PLACE : fns_pkg::ST_SHIFT;
        end else begin
          state_next = status.last_q ? fns_pkg::ST_SUM_READ : fns_pkg::ST_IDLE;
        end
      end
      fns_pkg::ST_PLACE: begin
        state_next = status.last_q ? fns_pkg::ST_SUM_READ : fns_pkg::ST_IDLE;
      end
      fns_pkg::ST_SUM_READ: begin
        if (status.slot_last) begin
          state_next = fns_pkg::ST_SUM_WAIT;
        end
      end
      fns_pkg::ST_SUM_WAIT:   state_next = fns_pkg::ST_CALC_QUART;
      fns_pkg::ST_CALC_QUART: state_next = fns_pkg::ST_CALC_FENCE;
      fns_pkg::ST_CALC_FENCE: state_next = fns_pkg::ST_IDLE;
      default:                state_next = fns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      fns_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
        cmd.drop   = start & status.full;
      end
      fns_pkg::ST_SHIFT: begin
        cmd.shift = status.greater;
        cmd.place = ~status.greater;
      end
      fns_pkg::ST_PLACE:      cmd.place      = 1'b1;
      fns_pkg::ST_SUM_READ:   cmd.sum_read   = 1'b1;
      fns_pkg::ST_SUM_WAIT:   cmd            = '0;
      fns_pkg::ST_CALC_QUART: cmd.calc_quart = 1'b1;
      fns_pkg::ST_CALC_FENCE: cmd.finish     = 1'b1;
      default:                cmd            = '0;
    endcase
  end

endmodule

>>> rtl/fns_datapath.sv
// fns_datapath: sorted sample store, insertion shifting and summary arithmetic
// depends on fns_pkg and fns_ram
`timescale 1ns / 1ps

module fns_datapath #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  input  fns_pkg::cmd_t                 cmd,
  output fns_pkg::status_t              status,
  output logic                          done,
  output logic signed [15:0]            min_value,
  output logic signed [15:0]            max_value,
  output logic signed [17:0]            first_quartile,
  output logic signed [17:0]            median_value,
  output logic signed [17:0]            third_quartile,
  output logic [17:0]                   spread,
  output logic signed [19:0]            lower_whisker,
  output logic signed [19:0]            upper_whisker,
  output logic [6:0]                    sample_count,
  output logic                          too_few,
  output logic                          dropped
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned QW = SB + 2;
  localparam int unsigned EW = SB + 6;
  localparam int unsigned SW = fns_pkg::SLOT_BITS;

  function automatic logic [AW-1:0] clamp_addr(input logic [CW-1:0] a);
    logic [AW-1:0] r;
    r = (a >= CW'(CAPACITY)) ? '0 : a[AW-1:0];
    return r;
  endfunction

  logic signed [SB-1:0] v;
  logic                 last_q;
  logic [CW-1:0]        count;
  logic                 overflow;
  logic [CW-1:0]        pos;
  logic [SW-1:0]        slot;
  logic                 cap_valid;
  logic [SW-1:0]        cap_slot;
  logic signed [SB-1:0] r [fns_pkg::NUM_SLOTS];
  logic signed [QW-1:0] q1, med, q3;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [SB-1:0]        wdata, rdata;

  // summary addresses
  logic [CW-1:0] half, hq, lo3, a_max, a_med_x, a_q1_x, a_q3_y, a_q3_x, sum_addr;

  // quartile arithmetic
  logic signed [SB:0]   med_sum, q1_sum, q3_sum;
  logic signed [EW-1:0] q1_e, q3_e, sp_e, tri_e, half_e, lw_e, uw_e;

  fns_ram #(
    .WIDTH(SB),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign we    = cmd.shift | cmd.place;
  assign waddr = pos[AW-1:0];
  assign wdata = cmd.shift ? rdata : v;

  assign half    = count >> 1;
  assign hq      = half >> 1;
  assign lo3     = half + CW'(count[0]);
  assign a_max   = count - CW'(1);
  assign a_med_x = count[0] ? half : half - CW'(1);
  assign a_q1_x  = half[0] ? hq : hq - CW'(1);
  assign a_q3_y  = lo3 + hq;
  assign a_q3_x  = half[0] ? a_q3_y : a_q3_y - CW'(1);

  always_comb begin
    case (slot)
      SW'(fns_pkg::SLOT_MIN):   sum_addr = '0;
      SW'(fns_pkg::SLOT_MAX):   sum_addr = a_max;
      SW'(fns_pkg::SLOT_MED_X): sum_addr = a_med_x;
      SW'(fns_pkg::SLOT_MED_Y): sum_addr = half;
      SW'(fns_pkg::SLOT_Q1_X):  sum_addr = a_q1_x;
      SW'(fns_pkg::SLOT_Q1_Y):  sum_addr = hq;
      SW'(fns_pkg::SLOT_Q3_X):  sum_addr = a_q3_x;
      SW'(fns_pkg::SLOT_Q3_Y):  sum_addr = a_q3_y;
      default:                  sum_addr = '0;
    endcase
  end

  always_comb begin
    if (cmd.accept) begin
      raddr = clamp_addr(count - CW'(1));
    end else if (cmd.shift) begin
      raddr = clamp_addr(pos - CW'(2));
    end else begin
      raddr = clamp_addr(sum_addr);
    end
  end

  assign status.full      = (count == CW'(CAPACITY));
  assign status.empty     = (count == '0);
  assign status.greater   = ($signed(rdata) > v);
  assign status.pos_one   = (pos == CW'(1));
  assign status.last_q    = last_q;
  assign status.slot_last = (slot == SW'(fns_pkg::NUM_SLOTS - 1));

  // insertion and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      cap_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      cap_valid <= cmd.sum_read;
      done      <= cmd.finish;
      if (cmd.drop) begin
        overflow <= 1'b1;
      end
      if (cmd.place) begin
        count <= count + CW'(1);
      end
      if (cmd.finish) begin
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v      <= sample;
      last_q <= last;
      pos    <= count;
      slot   <= '0;
    end
    if (cmd.shift) begin
      pos <= pos - CW'(1);
    end
    if (cmd.sum_read) begin
      slot <= slot + SW'(1);
    end
    cap_slot <= slot;
    if (cap_valid) begin
      r[cap_slot] <= $signed(rdata);
    end
  end

  // medians as 2*(x+y), x = y for odd lengths
  assign med_sum = {r[fns_pkg::SLOT_MED_X][SB-1], r[fns_pkg::SLOT_MED_X]}
                 + {r[fns_pkg::SLOT_MED_Y][SB-1], r[fns_pkg::SLOT_MED_Y]};
  assign q1_sum  = {r[fns_pkg::SLOT_Q1_X][SB-1], r[fns_pkg::SLOT_Q1_X]}
                 + {r[fns_pkg::SLOT_Q1_Y][SB-1], r[fns_pkg::SLOT_Q1_Y]};
  assign q3_sum  = {r[fns_pkg::SLOT_Q3_X][SB-1], r[fns_pkg::SLOT_Q3_X]}
                 + {r[fns_pkg::SLOT_Q3_Y][SB-1], r[fns_pkg::SLOT_Q3_Y]};

  always_ff @(posedge clk) begin
    if (cmd.calc_quart) begin
      med <= {med_sum, 1'b0};
      q1  <= {q1_sum, 1'b0};
      q3  <= {q3_sum, 1'b0};
    end
  end

  // spread is never negative, so halving is a plain shift
  assign q1_e   = EW'(q1);
  assign q3_e   = EW'(q3);
  assign sp_e   = q3_e - q1_e;
  assign tri_e  = sp_e + (sp_e <<< 1);
  assign half_e = tri_e >>> 1;
  assign lw_e   = q1_e - half_e;
  assign uw_e   = q3_e + half_e;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_count <= 7'(count);
      dropped      <= overflow;
      too_few      <= (count < CW'(2));
      if (count < CW'(2)) begin
        min_value      <= '0;
        max_value      <= '0;
        first_quartile <= '0;
        median_value   <= '0;
        third_quartile <= '0;
        spread         <= '0;
        lower_whisker  <= '0;
        upper_whisker  <= '0;
      end else begin
        min_value      <= 16'(r[fns_pkg::SLOT_MIN]);
        max_value      <= 16'(r[fns_pkg::SLOT_MAX]);
        first_quartile <= 18'(q1);
        median_value   <= 18'(med);
        third_quartile <= 18'(q3);
        spread         <= 18'(sp_e);
        lower_whisker  <= 20'(lw_e);
        upper_whisker  <= 20'(uw_e);
      end
    end
  end

endmodule

>>> rtl/five_number_summary.sv
// five_number_summary: top level of the box-plot summary block
// joins fns_ctrl and fns_datapath (which holds the fns_ram store); uses fns_pkg
`timescale 1ns / 1ps

// channel   | ports                                   | handshake
// ----------+-----------------------------------------+------------------------------
// sample in | sample, last                            | start high while busy low
// result    | min_value .. upper_whisker, sample_count,| done high for one cycle, no
//           | too_few, dropped                        | back-pressure
//
// steps: each sample is taken, then each stored entry larger than it is moved
//   up one place per cycle through the single ram port before the sample is
//   written into the hole; a sample on a full store is dropped and not stored
// a sample marked last then starts 8 summary reads, a wait for the read data,
//   a step for median and quartiles and one for spread and fences; done
//   rises in the cycle after, while busy is already low
// reset clears the controller, the sample count and the overflow flag; the
//   store contents are left as they are
// the receiver cannot stall: each result transaction lasts exactly one cycle

module five_number_summary #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  output logic                          done,
  output logic signed [15:0]            min_value,
  output logic signed [15:0]            max_value,
  output logic signed [17:0]            first_quartile,
  output logic signed [17:0]            median_value,
  output logic signed [17:0]            third_quartile,
  output logic [17:0]                   spread,
  output logic signed [19:0]            lower_whisker,
  output logic signed [19:0]            upper_whisker,
  output logic [6:0]                    sample_count,
  output logic                          too_few,
  output logic                          dropped
);

  // command and status between controller and datapath
  fns_pkg::cmd_t    cmd;
  fns_pkg::status_t status;

  // controller: insertion walk, summary read sequence, result arithmetic
  fns_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (last),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: sorted store, count, overflow flag, quartile and fence maths
  fns_datapath #(
    .CAPACITY   (CAPACITY),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample),
    .last          (last),
    .cmd           (cmd),
    .status        (status),
    .done          (done),
    .min_value     (min_value),
    .max_value     (max_value),
    .first_quartile(first_quartile),
    .median_value  (median_value),
    .third_quartile(third_quartile),
    .spread        (spread),
    .lower_whisker (lower_whisker),
    .upper_whisker (upper_whisker),
    .sample_count  (sample_count),
    .too_few       (too_few),
    .dropped       (dropped)
  );

  // a result transaction only follows the fence step and leaves the block idle
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe while block still busy");

  // with too few samples min, max, median, spread and lower whisker are zero
  a_too_few_zero : assert property (@(posedge clk) disable iff (rst)
    done && too_few |-> min_value == '0 && max_value == '0 && spread == '0
                        && median_value == '0 && lower_whisker == '0)
    else $error("too-few result carries non-zero values");

  // min is at most max and the quartiles are ordered
  a_order : assert property (@(posedge clk) disable iff (rst)
    (SAMPLE_BITS <= 16) && done && !too_few |->
      min_value <= max_value && first_quartile <= median_value
      && median_value <= third_quartile)
    else $error("summary values out of order");

  // a new transaction is never taken while the controller is working
  a_no_accept_busy : assert property (@(posedge clk) disable iff (rst)
    busy |-> !u_ctrl.cmd.accept)
    else $error("sample accepted while busy");

endmodule
